@@ rtl/core/scda_pkg.sv @@
// Shared types, codes and sizes for the sparse column dot and axpy engine.
package scda_pkg;

  localparam int unsigned VECTOR_DEPTH    = 1024;
  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam int unsigned RES_QUEUE_DEPTH = 2;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned SUM_W           = 64;
  localparam int unsigned CFG_IDX_W       = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_SELECT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b1;

  // Result kinds
  localparam logic RES_SUM   = 1'b0;
  localparam logic RES_ENTRY = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_COLUMN = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_DOT  = 2'd0,
    OP_WDOT = 2'd1,
    OP_HSQ  = 2'd2,
    OP_AXPY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_COLUMN = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MUL1 = 3'd1,
    ST_MUL2 = 3'd2,
    ST_ACC  = 3'd3,
    ST_READ = 3'd4
  } back_state_e;

  typedef struct packed {
    logic [1:0]                mode;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] entry_weight;
    logic                      last_entry;
  } in_item_t;

  typedef struct packed {
    logic                      result_kind;
    logic signed [SUM_W-1:0]   result_value;
    logic                      saturated;
  } res_item_t;

  // Classified work handed from the front to the back
  typedef struct packed {
    cmd_e                      kind;
    op_e                       op;
    logic                      hit;
    logic                      last_entry;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic signed [VALUE_W-1:0] entry_weight;
  } cmd_t;

endpackage

@@ rtl/core/scda_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scda_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/scda_fifo.sv @@
// Small register queue used between the front, the back and the result port.
module scda_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] slots_q [Depth];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/scda_front.sv @@
// Front end: configuration registers, item classification and the command queue.
module scda_front #(
  parameter int unsigned VectorDepth = scda_pkg::VECTOR_DEPTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  scda_pkg::in_item_t                     item_i,
  output logic                                   full_o,
  input  logic                                   cfg_we_i,
  input  logic [scda_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [scda_pkg::VALUE_W-1:0]           cfg_wdata_i,
  output logic signed [scda_pkg::VALUE_W-1:0]    scale_factor_o,
  output logic                                   cmd_valid_o,
  output scda_pkg::cmd_t                         cmd_o,
  input  logic                                   cmd_pop_i
);
  import scda_pkg::*;

  op_e                       op_select_q;
  logic signed [VALUE_W-1:0] scale_factor_q;
  cmd_t                      cmd_d;
  logic                      keep, hit, q_empty;
  logic [$bits(cmd_t)-1:0]   q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_select_q    <= OP_DOT;
      scale_factor_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OP_SELECT:    op_select_q    <= op_e'(cfg_wdata_i[1:0]);
        REG_SCALE_FACTOR: scale_factor_q <= $signed(cfg_wdata_i);
        default:          op_select_q    <= op_select_q;
      endcase
    end
  end

  assign scale_factor_o = scale_factor_q;
  assign hit = (32'(item_i.entry_index) < 32'(VectorDepth));

  // Drop items that leave no trace: out-of-range loads, out-of-range
  // nonzeros that do not close a column, and the unused mode.
  always_comb begin
    cmd_d.op           = op_select_q;
    cmd_d.hit          = hit;
    cmd_d.last_entry   = item_i.last_entry;
    cmd_d.entry_index  = item_i.entry_index;
    cmd_d.entry_value  = item_i.entry_value;
    cmd_d.entry_weight = item_i.entry_weight;
    case (item_i.mode)
      MODE_LOAD: begin
        cmd_d.kind = CMD_LOAD;
        keep       = hit;
      end
      MODE_COLUMN: begin
        cmd_d.kind = CMD_COLUMN;
        keep       = hit || item_i.last_entry;
      end
      MODE_READ: begin
        cmd_d.kind = CMD_READ;
        keep       = 1'b1;
      end
      default: begin
        cmd_d.kind = CMD_LOAD;
        keep       = 1'b0;
      end
    endcase
  end

  scda_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (cmd_d),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_t'(q_rdata);

endmodule

@@ rtl/core/scda_back.sv @@
// Back end: vector and weight stores, shared multiplier and saturating accumulator.
module scda_back #(
  parameter int unsigned VectorDepth = scda_pkg::VECTOR_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  scda_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  logic signed [scda_pkg::VALUE_W-1:0] scale_factor_i,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output scda_pkg::res_item_t                 res_o
);
  import scda_pkg::*;

  localparam int unsigned AW = $clog2(VectorDepth);

  back_state_e               state_q, state_d;
  cmd_t                      cmd_q;
  logic signed [SUM_W-1:0]   prod_q, mul_p;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic                      sat_q, sat_d;
  logic                      needs_res, start;
  logic signed [VALUE_W-1:0] mul_a, mul_b;
  logic [VALUE_W:0]          p_sat, axpy_sat;
  logic [SUM_W:0]            acc_sat;
  logic signed [SUM_W-1:0]   acc_term;
  logic                      ram_re, vec_we, wgt_we;
  logic [AW-1:0]             raddr, vec_waddr;
  logic [VALUE_W-1:0]        vec_wdata, vec_rdata, wgt_rdata;

  // {clamped, value}: clamp to the signed 32-bit range
  function automatic logic [VALUE_W:0] sat32(input logic signed [SUM_W-1:0] x);
    logic in_range;
    in_range = (&x[SUM_W-1:VALUE_W-1]) || !(|x[SUM_W-1:VALUE_W-1]);
    if (in_range) begin
      return {1'b0, x[VALUE_W-1:0]};
    end
    return {1'b1, x[SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff};
  endfunction

  // {clamped, sum}: 64-bit add that sticks at the rails
  function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                              input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return {1'b1, s[SUM_W], {(SUM_W - 1){!s[SUM_W]}}};
    end
    return {1'b0, s[SUM_W-1:0]};
  endfunction

  assign needs_res = (cmd_i.kind == CMD_READ) ||
                     ((cmd_i.kind == CMD_COLUMN) && cmd_i.last_entry);
  assign start     = (state_q == ST_IDLE) && cmd_valid_i && !(needs_res && res_full_i);

  assign mul_p    = mul_a * mul_b;
  assign p_sat    = sat32(prod_q >>> 16);
  assign axpy_sat = sat32($signed({{(SUM_W - VALUE_W){vec_rdata[VALUE_W-1]}}, vec_rdata})
                          + (prod_q >>> 16));
  assign acc_term = (cmd_q.hit && (cmd_q.op != OP_AXPY)) ? prod_q : '0;
  assign acc_sat  = sat_add(sum_q, acc_term);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_i.kind)
            CMD_READ:   state_d = ST_READ;
            CMD_COLUMN: state_d = cmd_i.hit ? ST_MUL1 : ST_ACC;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL1: state_d = (cmd_q.op == OP_DOT) ? ST_ACC : ST_MUL2;
      ST_MUL2: state_d = ST_ACC;
      ST_ACC:  state_d = ST_IDLE;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    ram_re     = 1'b0;
    raddr      = AW'(cmd_i.entry_index);
    vec_we     = 1'b0;
    wgt_we     = 1'b0;
    vec_waddr  = AW'(cmd_i.entry_index);
    vec_wdata  = cmd_i.entry_value;
    mul_a      = '0;
    mul_b      = '0;
    sum_d      = sum_q;
    sat_d      = sat_q;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = start;
        ram_re    = start && cmd_i.hit && (cmd_i.kind != CMD_LOAD);
        vec_we    = start && cmd_i.hit && (cmd_i.kind == CMD_LOAD);
        wgt_we    = vec_we;
      end
      ST_MUL1: begin
        mul_a = cmd_q.entry_value;
        case (cmd_q.op)
          OP_HSQ:  mul_b = cmd_q.entry_value;
          OP_AXPY: mul_b = scale_factor_i;
          default: mul_b = $signed(vec_rdata);
        endcase
      end
      ST_MUL2: begin
        if (cmd_q.op == OP_AXPY) begin
          vec_we    = 1'b1;
          vec_waddr = AW'(cmd_q.entry_index);
          vec_wdata = axpy_sat[VALUE_W-1:0];
          sat_d     = sat_q | axpy_sat[VALUE_W];
        end else begin
          mul_a = $signed(p_sat[VALUE_W-1:0]);
          mul_b = $signed(wgt_rdata);
          sat_d = sat_q | p_sat[VALUE_W];
        end
      end
      ST_ACC: begin
        if (cmd_q.last_entry) begin
          res_push_o         = 1'b1;
          res_o.result_kind  = RES_SUM;
          res_o.result_value = $signed(acc_sat[SUM_W-1:0]);
          res_o.saturated    = sat_q | acc_sat[SUM_W];
          sum_d              = '0;
          sat_d              = 1'b0;
        end else begin
          sum_d = $signed(acc_sat[SUM_W-1:0]);
          sat_d = sat_q | acc_sat[SUM_W];
        end
      end
      ST_READ: begin
        res_push_o         = 1'b1;
        res_o.result_kind  = RES_ENTRY;
        res_o.result_value = cmd_q.hit
                             ? $signed({{(SUM_W - VALUE_W){vec_rdata[VALUE_W-1]}}, vec_rdata})
                             : '0;
        res_o.saturated    = 1'b0;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= cmd_i;
    end
    if ((state_q == ST_MUL1) || (state_q == ST_MUL2)) begin
      prod_q <= mul_p;
    end
  end

  scda_ram #(
    .Width (VALUE_W),
    .Depth (VectorDepth)
  ) u_vector_store (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (vec_waddr),
    .wdata_i (vec_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (vec_rdata)
  );

  scda_ram #(
    .Width (VALUE_W),
    .Depth (VectorDepth)
  ) u_weight_store (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (AW'(cmd_i.entry_index)),
    .wdata_i (cmd_i.entry_weight),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (wgt_rdata)
  );

endmodule

@@ rtl/core/sparse_column_dot_and_axpy.sv @@
// Top level of the sparse column dot product and axpy engine.
//
//   channel   direction  handshake               payload
//   input     in         push / full             in_item_i  (in_item_t)
//   result    out        empty / pop             out_item_o (res_item_t)
//   config    in         cfg_we_i, cfg_idx_i     cfg_wdata_i
//
// The front takes one item per cycle into a two-entry command queue while it has room.
// The back runs one command at a time with a single 32x32 multiplier: a load writes
// from idle; a read runs ST_READ; a nonzero runs ST_MUL1, ST_MUL2 (not for dot) and
// ST_ACC; an out-of-range column close only ST_ACC. A command that yields a result
// waits while the two-entry result queue is full. Reset clears control, configuration
// and the sum; the stores are undefined until written and get no clearing pass.
module sparse_column_dot_and_axpy #(
  parameter int unsigned VectorDepth = scda_pkg::VECTOR_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  scda_pkg::in_item_t            in_item_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output scda_pkg::res_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [scda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [scda_pkg::VALUE_W-1:0]  cfg_wdata_i
);
  import scda_pkg::*;

  logic                         cmd_valid, cmd_pop, res_push, res_full;
  cmd_t                         cmd;
  res_item_t                    res_item;
  logic signed [VALUE_W-1:0]    scale_factor;
  logic [$bits(res_item_t)-1:0] res_rdata;

  scda_front #(
    .VectorDepth (VectorDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .item_i         (in_item_i),
    .full_o         (full),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .scale_factor_o (scale_factor),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  scda_back #(
    .VectorDepth (VectorDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .scale_factor_i (scale_factor),
    .res_full_i     (res_full),
    .res_push_o     (res_push),
    .res_o          (res_item)
  );

  scda_fifo #(
    .Width ($bits(res_item_t)),
    .Depth (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_item_o = res_item_t'(res_rdata);

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back took a command from an empty queue");

  a_readback_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (res_item.result_kind == RES_ENTRY)) |-> !res_item.saturated)
    else $error("read-back result carries a saturation flag");

  a_no_result_without_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> $past(cmd_pop) || $past(cmd_pop, 2) || $past(cmd_pop, 3))
    else $error("result produced without a command");

endmodule

@@ test/sparse_column_dot_and_axpy_test.sv @@
// Self-checking testbench for the sparse column dot product and axpy engine.
`timescale 1ns / 1ps

module sparse_column_dot_and_axpy_test;
  import scda_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 60;

  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [VALUE_W-1:0] Q_HALF = 32'h0000_8000;
  localparam logic [VALUE_W-1:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] Q_NEG_LSB = 32'hffff_ffff;

  // Mirrors the stores, the column sum and the registers; holds results still owed.
  class column_scoreboard;
    logic signed [VALUE_W-1:0] vec_mem [VECTOR_DEPTH];
    logic signed [VALUE_W-1:0] wgt_mem [VECTOR_DEPTH];
    logic signed [SUM_W-1:0]   col_sum;
    bit                        col_sat;
    op_e                       op;
    logic signed [VALUE_W-1:0] scale;
    res_item_t                 owed_q[$];
    int unsigned               errors;
    int unsigned               results_checked;
    int unsigned               columns_closed;
    int unsigned               reads_done;

    function new();
      col_sum = '0;
      col_sat = 1'b0;
      op = OP_DOT;
      scale = '0;
      errors = 0;
      results_checked = 0;
      columns_closed = 0;
      reads_done = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      if (idx == REG_OP_SELECT) op = op_e'(data[1:0]);
      else scale = data;
    endfunction

    function logic signed [VALUE_W-1:0] clamp32(longint x);
      if (x > 64'sd2147483647) begin
        col_sat = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (x < -64'sd2147483648) begin
        col_sat = 1'b1;
        return 32'sh8000_0000;
      end
      return x[VALUE_W-1:0];
    endfunction

    function void add_term(longint term);
      logic [SUM_W:0] s;
      s = {col_sum[SUM_W-1], col_sum} + {term[63], term};
      // Clamp on signed overflow of the 64-bit sum.
      if (s[SUM_W] != s[SUM_W-1]) begin
        col_sat = 1'b1;
        col_sum = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        col_sum = s[SUM_W-1:0];
      end
    endfunction

    function void note_input(in_item_t it);
      longint    v, x, w, p;
      res_item_t r;
      bit        hit;
      hit = it.entry_index < VECTOR_DEPTH;
      v = it.entry_value;
      r = '0;
      case (it.mode)
        MODE_LOAD: begin
          if (hit) begin
            vec_mem[it.entry_index] = it.entry_value;
            wgt_mem[it.entry_index] = it.entry_weight;
          end
        end
        MODE_READ: begin
          r.result_kind = RES_ENTRY;
          if (hit) r.result_value = vec_mem[it.entry_index];
          owed_q = {owed_q, r};
          reads_done++;
        end
        MODE_COLUMN: begin
          if (hit) begin
            x = vec_mem[it.entry_index];
            w = wgt_mem[it.entry_index];
            case (op)
              OP_DOT: add_term(v * x);
              OP_WDOT: begin
                p = clamp32((v * x) >>> 16);
                add_term(p * w);
              end
              OP_HSQ: begin
                p = clamp32((v * v) >>> 16);
                add_term(p * w);
              end
              default: vec_mem[it.entry_index] = clamp32(x + ((v * longint'(scale)) >>> 16));
            endcase
          end
          if (it.last_entry) begin
            r.result_kind = RES_SUM;
            r.result_value = col_sum;
            r.saturated = col_sat;
            owed_q = {owed_q, r};
            col_sum = '0;
            col_sat = 1'b0;
            columns_closed++;
          end
        end
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(res_item_t got);
      res_item_t want;
      results_checked++;
      if (owed_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed (kind %0d value %0h)",
                         results_checked, got.result_kind, got.result_value));
        return;
      end
      want = owed_q.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result %0d kind got %0d want %0d",
                         results_checked, got.result_kind, want.result_kind));
      if (got.result_value !== want.result_value)
        report($sformatf("result %0d value got %0h want %0h",
                         results_checked, got.result_value, want.result_value));
      if (got.saturated !== want.saturated)
        report($sformatf("result %0d saturated got %0d want %0d",
                         results_checked, got.saturated, want.saturated));
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 push      = 1'b0;
  logic                 pop       = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [VALUE_W-1:0]   cfg_wdata = '0;
  in_item_t             in_item   = '0;
  logic                 full;
  logic                 empty;
  res_item_t            out_item;

  column_scoreboard   sb;
  bit                 written [VECTOR_DEPTH];
  logic [INDEX_W-1:0] written_list[$];
  bit                 steady = 1'b0;
  int unsigned        rx_hold_cycles = 0;
  int unsigned        items_sent = 0;
  int unsigned        settings_used = 0;
  int unsigned        col_left = 0;
  int unsigned        quiet_cycles = 0;

  sparse_column_dot_and_axpy dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mix of extremes, zero, full-range and modest Q16.16 values.
  function automatic logic [VALUE_W-1:0] rand_q();
    logic [VALUE_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: return raw;
      default: return $signed(raw) >>> $urandom_range(8, 20);
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, logic [INDEX_W-1:0] idx,
                                         logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] wgt,
                                         logic last);
    in_item_t it;
    it.mode = mode;
    it.entry_index = idx;
    it.entry_value = val;
    it.entry_weight = wgt;
    it.last_entry = last;
    return it;
  endfunction

  // Reads and nonzeros only touch rows that were loaded.
  function automatic in_item_t random_item();
    int unsigned        roll;
    logic [INDEX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    idx = written_list[$urandom_range(0, written_list.size() - 1)];
    if (roll < 15)
      return make_item(MODE_LOAD, INDEX_W'($urandom), rand_q(), rand_q(), 1'($urandom));
    if (roll < 23)
      return make_item(MODE_READ, idx, $urandom, $urandom, 1'($urandom));
    if (roll < 26)
      return make_item(MODE_UNUSED, INDEX_W'($urandom), $urandom, $urandom, 1'($urandom));
    if (col_left == 0) col_left = $urandom_range(1, 8);
    col_left--;
    return make_item(MODE_COLUMN, idx, rand_q(), $urandom, col_left == 0);
  endfunction

  task automatic offer(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
    items_sent++;
    if (it.mode == MODE_LOAD && !written[it.entry_index]) begin
      written[it.entry_index] = 1'b1;
      written_list = {written_list, it.entry_index};
    end
  endtask

  // Hold the input until every owed result is out and the back end has gone quiet.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic configure(op_e op, logic [VALUE_W-1:0] scale);
    settle();
    write_reg(REG_OP_SELECT, VALUE_W'(op));
    write_reg(REG_SCALE_FACTOR, scale);
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("sparse_column_dot_and_axpy_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_drain
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] scale;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    configure(OP_DOT, '0);
    offer(make_item(MODE_LOAD, 10'd0, Q_MAX, Q_MAX, 1'b0));
    offer(make_item(MODE_LOAD, 10'd1023, Q_MIN, Q_MIN, 1'b1));
    offer(make_item(MODE_LOAD, 10'd5, Q_ONE, 32'h0002_0000, 1'b0));
    offer(make_item(MODE_LOAD, 10'd6, Q_NEG_LSB, 32'h0000_0001, 1'b0));
    offer(make_item(MODE_READ, 10'd0, '0, '0, 1'b0));
    offer(make_item(MODE_READ, 10'd1023, Q_MAX, Q_MAX, 1'b1));
    offer(make_item(MODE_UNUSED, 10'd1023, Q_MIN, Q_MAX, 1'b1));
    // Two full-scale products overflow the 64-bit sum.
    offer(make_item(MODE_COLUMN, 10'd1023, Q_MIN, '0, 1'b0));
    offer(make_item(MODE_COLUMN, 10'd1023, Q_MIN, '0, 1'b1));
    offer(make_item(MODE_COLUMN, 10'd5, Q_MAX, '0, 1'b1));

    configure(OP_WDOT, '0);
    offer(make_item(MODE_COLUMN, 10'd0, Q_MAX, '0, 1'b0));
    offer(make_item(MODE_COLUMN, 10'd5, Q_ONE, '0, 1'b1));

    configure(OP_HSQ, '0);
    offer(make_item(MODE_COLUMN, 10'd6, Q_MIN, '0, 1'b0));
    offer(make_item(MODE_COLUMN, 10'd5, Q_NEG_LSB, '0, 1'b1));

    // Switch the operation with a column still open.
    configure(OP_DOT, '0);
    offer(make_item(MODE_COLUMN, 10'd5, Q_ONE, '0, 1'b0));
    configure(OP_WDOT, '0);
    offer(make_item(MODE_COLUMN, 10'd6, Q_ONE, '0, 1'b1));

    configure(OP_AXPY, Q_MAX);
    offer(make_item(MODE_COLUMN, 10'd0, Q_MAX, '0, 1'b1));
    offer(make_item(MODE_READ, 10'd0, '0, '0, 1'b0));
    configure(OP_AXPY, Q_MIN);
    offer(make_item(MODE_COLUMN, 10'd6, Q_ONE, '0, 1'b1));
    offer(make_item(MODE_READ, 10'd6, '0, '0, 1'b0));
    offer(make_item(MODE_COLUMN, 10'd5, Q_HALF, '0, 1'b1));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 5)
        0: scale = Q_MAX;
        1: scale = Q_MIN;
        2: scale = '0;
        3: scale = rand_q();
        default: scale = $urandom;
      endcase
      configure(ph < 4 ? op_e'(ph) : op_e'($urandom_range(0, 3)), scale);
      steady = (ph == 6);
      // Stall the result side long enough to back up the whole pipe.
      if (ph == 3) rx_hold_cycles = LONG_HOLD;
      repeat (PHASE_ITEMS) offer(random_item());
    end
    steady = 1'b0;

    settle();
    $display("covered %0d items, %0d results: %0d column sums and %0d read-backs",
             items_sent, sb.results_checked, sb.columns_closed, sb.reads_done);
    $display("over %0d register settings of all four operations, with stalls on both sides",
             settings_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sparse_column_dot_and_axpy_test: clean");
    end else begin
      $display("sparse_column_dot_and_axpy_test: errors");
    end
    $finish;
  end

endmodule

@@ sparse_column_dot_and_axpy.f @@
rtl/core/scda_pkg.sv
rtl/core/scda_ram.sv
rtl/core/scda_fifo.sv
rtl/core/scda_front.sv
rtl/core/scda_back.sv
rtl/core/sparse_column_dot_and_axpy.sv
test/sparse_column_dot_and_axpy_test.sv
